/* rtl/core/assert_macros.svh */
// Assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define LSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LSI_ASSERT(label, prop, msg)
`define LSI_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/core/lsi_pkg.sv */
package lsi_pkg;

    localparam int CW  = 16;            // coordinate width
    localparam int AW  = CW + 1;        // a, b
    localparam int PW  = 2 * CW;        // coordinate products
    localparam int CCW = 2 * CW + 1;    // c
    localparam int MW  = AW + CW;       // side term products
    localparam int DPW = 2 * AW;        // determinant products
    localparam int DW  = 2 * AW + 1;    // determinant
    localparam int RW  = 2 * CW + 3;    // side values
    localparam int NPW = AW + CCW;      // numerator products
    localparam int NW  = NPW + 1;       // numerators
    localparam int RMW = NW + 1;        // divider remainder / divisor

    localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_INTERSECT = 2'd0,
        ST_PARALLEL  = 2'd1,
        ST_DISJOINT  = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        logic    neg_x;
        logic    neg_y;
        logic    ovf_x;
        logic    ovf_y;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [RMW-1:0]   rem_x;
        logic [RMW-1:0]   rem_y;
        logic [RMW-1:0]   dsh;
        logic [CW-1:0]    q_x;
        logic [CW-1:0]    q_y;
    } div_t;

endpackage

/* rtl/core/lsi_front.sv */
module lsi_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          seg,
    input  logic signed [lsi_pkg::CW-1:0] x1,
    input  logic signed [lsi_pkg::CW-1:0] y1,
    input  logic signed [lsi_pkg::CW-1:0] x2,
    input  logic signed [lsi_pkg::CW-1:0] y2,
    input  logic signed [lsi_pkg::CW-1:0] x3,
    input  logic signed [lsi_pkg::CW-1:0] y3,
    input  logic signed [lsi_pkg::CW-1:0] x4,
    input  logic signed [lsi_pkg::CW-1:0] y4,
    output logic                          out_valid,
    output lsi_pkg::div_t                 out_data,
    input  logic                          out_ready
);

    localparam int CW  = lsi_pkg::CW;
    localparam int AW  = lsi_pkg::AW;
    localparam int PW  = lsi_pkg::PW;
    localparam int CCW = lsi_pkg::CCW;
    localparam int MW  = lsi_pkg::MW;
    localparam int DPW = lsi_pkg::DPW;
    localparam int DW  = lsi_pkg::DW;
    localparam int RW  = lsi_pkg::RW;
    localparam int NPW = lsi_pkg::NPW;
    localparam int NW  = lsi_pkg::NW;
    localparam int RMW = lsi_pkg::RMW;

    logic [4:0] v_reg;
    logic [4:0] rdy;

    // stage 1
    logic signed [AW-1:0]  a1_1_reg, b1_1_reg, a2_1_reg, b2_1_reg;
    logic signed [PW-1:0]  p21_reg, p12_reg, p43_reg, p34_reg;
    logic signed [CW-1:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg, x4_reg, y4_reg;
    logic                  seg1_reg;
    // stage 2
    logic signed [AW-1:0]  a1_2_reg, b1_2_reg, a2_2_reg, b2_2_reg;
    logic signed [CCW-1:0] c1_2_reg, c2_2_reg;
    logic signed [DPW-1:0] dp1_reg, dp2_reg;
    logic signed [MW-1:0]  m_reg [8];
    logic                  seg2_reg;
    // stage 3
    logic signed [DW-1:0]  det_reg;
    logic signed [RW-1:0]  r1_reg, r2_reg, r3_reg, r4_reg;
    logic signed [NPW-1:0] n1_reg, n2_reg, n3_reg, n4_reg;
    logic                  seg3_reg;
    // stage 4
    lsi_pkg::status_t      st4_reg;
    logic                  negx4_reg, negy4_reg;
    logic [NW-1:0]         mx4_reg, my4_reg;
    logic [DW-1:0]         md4_reg;
    // stage 5
    lsi_pkg::div_t         d5_reg;

    logic signed [CCW-1:0] c1_next, c2_next;
    logic signed [NW-1:0]  nx_next, ny_next;
    logic                  cross_a, cross_b;
    lsi_pkg::status_t      st_next;

    always_comb begin
        rdy[4] = !v_reg[4] || out_ready;
        rdy[3] = !v_reg[3] || rdy[4];
        rdy[2] = !v_reg[2] || rdy[3];
        rdy[1] = !v_reg[1] || rdy[2];
        rdy[0] = !v_reg[0] || rdy[1];
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[4];
    assign out_data  = d5_reg;

    always_comb begin
        c1_next = CCW'(p21_reg) - CCW'(p12_reg);
        c2_next = CCW'(p43_reg) - CCW'(p34_reg);
        nx_next = NW'(n1_reg) - NW'(n2_reg);
        ny_next = NW'(n3_reg) - NW'(n4_reg);
        cross_a = (r3_reg < 0 && r4_reg < 0) || (r3_reg > 0 && r4_reg > 0);
        cross_b = (r1_reg < 0 && r2_reg < 0) || (r1_reg > 0 && r2_reg > 0);
        if (seg3_reg && (cross_a || cross_b)) begin
            st_next = lsi_pkg::ST_DISJOINT;
        end else if (det_reg == '0) begin
            st_next = lsi_pkg::ST_PARALLEL;
        end else begin
            st_next = lsi_pkg::ST_INTERSECT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a1_1_reg <= AW'(y2) - AW'(y1);
            b1_1_reg <= AW'(x1) - AW'(x2);
            a2_1_reg <= AW'(y4) - AW'(y3);
            b2_1_reg <= AW'(x3) - AW'(x4);
            p21_reg  <= x2 * y1;
            p12_reg  <= x1 * y2;
            p43_reg  <= x4 * y3;
            p34_reg  <= x3 * y4;
            x1_reg   <= x1; y1_reg <= y1; x2_reg <= x2; y2_reg <= y2;
            x3_reg   <= x3; y3_reg <= y3; x4_reg <= x4; y4_reg <= y4;
            seg1_reg <= seg;
        end
        if (rdy[1]) begin
            a1_2_reg <= a1_1_reg; b1_2_reg <= b1_1_reg;
            a2_2_reg <= a2_1_reg; b2_2_reg <= b2_1_reg;
            c1_2_reg <= c1_next;
            c2_2_reg <= c2_next;
            dp1_reg  <= a1_1_reg * b2_1_reg;
            dp2_reg  <= a2_1_reg * b1_1_reg;
            m_reg[0] <= a1_1_reg * x3_reg;
            m_reg[1] <= b1_1_reg * y3_reg;
            m_reg[2] <= a1_1_reg * x4_reg;
            m_reg[3] <= b1_1_reg * y4_reg;
            m_reg[4] <= a2_1_reg * x1_reg;
            m_reg[5] <= b2_1_reg * y1_reg;
            m_reg[6] <= a2_1_reg * x2_reg;
            m_reg[7] <= b2_1_reg * y2_reg;
            seg2_reg <= seg1_reg;
        end
        if (rdy[2]) begin
            det_reg  <= DW'(dp1_reg) - DW'(dp2_reg);
            r3_reg   <= RW'(m_reg[0]) + RW'(m_reg[1]) + RW'(c1_2_reg);
            r4_reg   <= RW'(m_reg[2]) + RW'(m_reg[3]) + RW'(c1_2_reg);
            r1_reg   <= RW'(m_reg[4]) + RW'(m_reg[5]) + RW'(c2_2_reg);
            r2_reg   <= RW'(m_reg[6]) + RW'(m_reg[7]) + RW'(c2_2_reg);
            n1_reg   <= b1_2_reg * c2_2_reg;
            n2_reg   <= b2_2_reg * c1_2_reg;
            n3_reg   <= a2_2_reg * c1_2_reg;
            n4_reg   <= a1_2_reg * c2_2_reg;
            seg3_reg <= seg2_reg;
        end
        if (rdy[3]) begin
            st4_reg   <= st_next;
            negx4_reg <= nx_next[NW-1] ^ det_reg[DW-1];
            negy4_reg <= ny_next[NW-1] ^ det_reg[DW-1];
            mx4_reg   <= nx_next[NW-1] ? NW'(-nx_next) : NW'(nx_next);
            my4_reg   <= ny_next[NW-1] ? NW'(-ny_next) : NW'(ny_next);
            md4_reg   <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        end
        if (rdy[4]) begin
            d5_reg.tag.status <= st4_reg;
            d5_reg.tag.neg_x  <= negx4_reg;
            d5_reg.tag.neg_y  <= negy4_reg;
            d5_reg.tag.ovf_x  <= RMW'(mx4_reg) >= (RMW'(md4_reg) << CW);
            d5_reg.tag.ovf_y  <= RMW'(my4_reg) >= (RMW'(md4_reg) << CW);
            d5_reg.rem_x      <= RMW'(mx4_reg);
            d5_reg.rem_y      <= RMW'(my4_reg);
            d5_reg.dsh        <= RMW'(md4_reg) << (CW - 1);
            d5_reg.q_x        <= '0;
            d5_reg.q_y        <= '0;
        end
    end

endmodule

/* rtl/core/lsi_div_cell.sv */
module lsi_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lsi_pkg::div_t in_data,
    output logic          out_valid,
    output lsi_pkg::div_t out_data,
    input  logic          out_ready
);

    logic          v_reg;
    lsi_pkg::div_t d_reg;
    lsi_pkg::div_t d_next;
    logic          bx, by;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb begin
        d_next     = in_data;
        bx         = in_data.rem_x >= in_data.dsh;
        by         = in_data.rem_y >= in_data.dsh;
        d_next.rem_x = bx ? in_data.rem_x - in_data.dsh : in_data.rem_x;
        d_next.rem_y = by ? in_data.rem_y - in_data.dsh : in_data.rem_y;
        d_next.q_x   = {in_data.q_x[lsi_pkg::CW-2:0], bx};
        d_next.q_y   = {in_data.q_y[lsi_pkg::CW-2:0], by};
        d_next.dsh   = in_data.dsh >> 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            d_reg <= d_next;
        end
    end

endmodule

/* rtl/core/line_segment_intersection_2d_top.sv */
// 2D line / segment intersection, signed Q8.8 coordinates.
// Input channel s_*: opcode (0 infinite lines, 1 bounded segments) and the
// start and end points of two lines. Result channel m_*: status
// (0 intersect, 1 parallel or colinear, 2 disjoint), the crossing point
// truncated toward zero, and point_clamped when a coordinate saturated.
// Both channels use valid/ready; one result per item, in order.
// The data path holds 22 register stages: 5 setup stages for the line
// coefficients, determinant and numerators, one divider cell per quotient
// bit (16 cells), and an output register.
// Throughput: one item per cycle unless stalled; each stage holds its own
// valid bit, so bubbles collapse and a new item is taken while a result waits.
// When m_ready is low the pipeline fills up behind the output register and
// s_ready drops only once every stage is occupied.
// Reset (aresetn low, synchronous) empties all stages; nothing else to
// initialize, the block keeps no state between items.
module line_segment_intersection_2d_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [lsi_pkg::CW-1:0] s_first_start_x,
    input  logic signed [lsi_pkg::CW-1:0] s_first_start_y,
    input  logic signed [lsi_pkg::CW-1:0] s_first_end_x,
    input  logic signed [lsi_pkg::CW-1:0] s_first_end_y,
    input  logic signed [lsi_pkg::CW-1:0] s_second_start_x,
    input  logic signed [lsi_pkg::CW-1:0] s_second_start_y,
    input  logic signed [lsi_pkg::CW-1:0] s_second_end_x,
    input  logic signed [lsi_pkg::CW-1:0] s_second_end_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic signed [lsi_pkg::CW-1:0] m_cross_x,
    output logic signed [lsi_pkg::CW-1:0] m_cross_y,
    output logic                          m_point_clamped
);

`include "assert_macros.svh"

    localparam int CW = lsi_pkg::CW;

    logic          cv   [CW+1];
    logic          cr   [CW+1];
    lsi_pkg::div_t cd   [CW+1];

    logic                 o_rdy;
    logic                 m_valid_reg;
    lsi_pkg::status_t     status_reg;
    logic [CW-1:0]        cx_reg, cy_reg;
    logic                 clamp_reg;

    lsi_pkg::div_t        last;
    logic                 clx, cly;
    logic [CW-1:0]        cx_next, cy_next;

    lsi_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .seg       (s_opcode),
        .x1        (s_first_start_x),
        .y1        (s_first_start_y),
        .x2        (s_first_end_x),
        .y2        (s_first_end_y),
        .x3        (s_second_start_x),
        .y3        (s_second_start_y),
        .x4        (s_second_end_x),
        .y4        (s_second_end_y),
        .out_valid (cv[0]),
        .out_data  (cd[0]),
        .out_ready (cr[0])
    );

    for (genvar i = 0; i < CW; i++) begin : g_cell
        lsi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1]),
            .out_ready (cr[i+1])
        );
    end

    assign o_rdy  = !m_valid_reg || m_ready;
    assign cr[CW] = o_rdy;
    assign last   = cd[CW];

    always_comb begin
        clx = last.tag.ovf_x ||
              (last.q_x > (last.tag.neg_x ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS));
        cly = last.tag.ovf_y ||
              (last.q_y > (last.tag.neg_y ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS));
        if (clx) begin
            cx_next = last.tag.neg_x ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS;
        end else begin
            cx_next = last.tag.neg_x ? CW'(-last.q_x) : last.q_x;
        end
        if (cly) begin
            cy_next = last.tag.neg_y ? lsi_pkg::LIM_NEG : lsi_pkg::LIM_POS;
        end else begin
            cy_next = last.tag.neg_y ? CW'(-last.q_y) : last.q_y;
        end
        if (last.tag.status != lsi_pkg::ST_INTERSECT) begin
            cx_next = '0;
            cy_next = '0;
            clx     = 1'b0;
            cly     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (o_rdy) begin
            m_valid_reg <= cv[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (o_rdy) begin
            status_reg <= last.tag.status;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            clamp_reg  <= clx || cly;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_cross_x       = cx_reg;
    assign m_cross_y       = cy_reg;
    assign m_point_clamped = clamp_reg;

    `LSI_ASSERT(a_no_point, m_valid && m_status != lsi_pkg::ST_INTERSECT |-> m_cross_x == '0 && m_cross_y == '0 && !m_point_clamped, "point set without intersection")
    `LSI_ASSERT(a_status_code, m_valid |-> m_status == lsi_pkg::ST_INTERSECT || m_status == lsi_pkg::ST_PARALLEL || m_status == lsi_pkg::ST_DISJOINT, "bad status code")
    `LSI_ASSERT(a_clamp_val, m_valid && m_point_clamped |-> m_cross_x == lsi_pkg::LIM_POS || m_cross_x == lsi_pkg::LIM_NEG || m_cross_y == lsi_pkg::LIM_POS || m_cross_y == lsi_pkg::LIM_NEG, "clamp flag without limit value")

endmodule

/* test/lsi_checker.sv */
`timescale 1ns / 100ps

module lsi_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [lsi_pkg::CW-1:0] s_first_start_x,
    input  logic signed [lsi_pkg::CW-1:0] s_first_start_y,
    input  logic signed [lsi_pkg::CW-1:0] s_first_end_x,
    input  logic signed [lsi_pkg::CW-1:0] s_first_end_y,
    input  logic signed [lsi_pkg::CW-1:0] s_second_start_x,
    input  logic signed [lsi_pkg::CW-1:0] s_second_start_y,
    input  logic signed [lsi_pkg::CW-1:0] s_second_end_x,
    input  logic signed [lsi_pkg::CW-1:0] s_second_end_y,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [1:0]                    m_status,
    input  logic signed [lsi_pkg::CW-1:0] m_cross_x,
    input  logic signed [lsi_pkg::CW-1:0] m_cross_y,
    input  logic                          m_point_clamped,
    output int                            fail_count,
    output int                            pending
);

    localparam int CW = lsi_pkg::CW;

    typedef struct packed {
        lsi_pkg::status_t status;
        logic [CW-1:0]    cx;
        logic [CW-1:0]    cy;
        logic             clamped;
    } crossing_t;

    crossing_t crossings_due[$];

    // truncated quotient, saturated to the coordinate range
    function automatic logic [CW-1:0] sat_quot(input logic signed [127:0] num,
                                               input logic signed [127:0] den,
                                               inout logic clamped);
        logic signed [127:0] q;
        q = num / den;
        if (q > $signed(128'(2 ** (CW - 1) - 1))) begin
            clamped = 1'b1;
            return lsi_pkg::LIM_POS;
        end
        if (q < -$signed(128'(2 ** (CW - 1)))) begin
            clamped = 1'b1;
            return lsi_pkg::LIM_NEG;
        end
        return q[CW-1:0];
    endfunction

    function automatic crossing_t solve_crossing(input logic seg,
        input logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4);
        crossing_t r;
        logic signed [127:0] a1, b1, c1, a2, b2, c2, r1, r2, r3, r4, det;
        logic clamped;
        a1 = y2 - y1; b1 = x1 - x2; c1 = x2 * y1 - x1 * y2;
        a2 = y4 - y3; b2 = x3 - x4; c2 = x4 * y3 - x3 * y4;
        r = '0;
        clamped = 1'b0;
        if (seg) begin
            r3 = a1 * x3 + b1 * y3 + c1;
            r4 = a1 * x4 + b1 * y4 + c1;
            r1 = a2 * x1 + b2 * y1 + c2;
            r2 = a2 * x2 + b2 * y2 + c2;
            if ((r3 < 0 && r4 < 0) || (r3 > 0 && r4 > 0) ||
                (r1 < 0 && r2 < 0) || (r1 > 0 && r2 > 0)) begin
                r.status = lsi_pkg::ST_DISJOINT;
                return r;
            end
        end
        det = a1 * b2 - a2 * b1;
        if (det == 0) begin
            r.status = lsi_pkg::ST_PARALLEL;
            return r;
        end
        r.status = lsi_pkg::ST_INTERSECT;
        r.cx = sat_quot(b1 * c2 - b2 * c1, det, clamped);
        r.cy = sat_quot(a2 * c1 - a1 * c2, det, clamped);
        r.clamped = clamped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = crossings_due.size();

    always @(posedge aclk) begin
        crossing_t want;
        if (aresetn && s_valid && s_ready)
            crossings_due.push_back(solve_crossing(s_opcode,
                s_first_start_x, s_first_start_y, s_first_end_x, s_first_end_y,
                s_second_start_x, s_second_start_y, s_second_end_x, s_second_end_y));
        if (aresetn && m_valid && m_ready) begin
            if (crossings_due.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = crossings_due.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_cross_x !== want.cx)
                    report_mismatch("cross_x", m_cross_x, $signed(want.cx));
                if (m_cross_y !== want.cy)
                    report_mismatch("cross_y", m_cross_y, $signed(want.cy));
                if (m_point_clamped !== want.clamped)
                    report_mismatch("point_clamped", m_point_clamped, want.clamped);
            end
        end
    end
endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int CW           = lsi_pkg::CW;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT  = 2000;
    localparam int LATENCY      = 21;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_opcode = 1'b0;
    logic signed [CW-1:0] pt [8];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_status;
    logic signed [CW-1:0] m_cross_x, m_cross_y;
    logic m_point_clamped;
    int fail_count, pending, idle_cycles;

    initial foreach (pt[i]) pt[i] = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    line_segment_intersection_2d_top DUT (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode,
        .s_first_start_x(pt[0]), .s_first_start_y(pt[1]),
        .s_first_end_x(pt[2]), .s_first_end_y(pt[3]),
        .s_second_start_x(pt[4]), .s_second_start_y(pt[5]),
        .s_second_end_x(pt[6]), .s_second_end_y(pt[7]),
        .m_valid, .m_ready, .m_status, .m_cross_x, .m_cross_y, .m_point_clamped
    );

    lsi_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode,
        .s_first_start_x(pt[0]), .s_first_start_y(pt[1]),
        .s_first_end_x(pt[2]), .s_first_end_y(pt[3]),
        .s_second_start_x(pt[4]), .s_second_start_y(pt[5]),
        .s_second_end_x(pt[6]), .s_second_end_y(pt[7]),
        .m_valid, .m_ready, .m_status, .m_cross_x, .m_cross_y, .m_point_clamped,
        .fail_count, .pending
    );

    // receiver: alternates between open stretches and stall stretches
    initial begin
        int run;
        forever begin
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            repeat (run) begin
                @(negedge aclk);
                m_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic signed [CW-1:0] p [8]);
        s_opcode <= op;
        foreach (pt[i]) pt[i] <= p[i];
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 1024)) - 512);
            2: return $urandom_range(0, 1) ? lsi_pkg::LIM_POS : lsi_pkg::LIM_NEG;
            default: return CW'($signed($urandom_range(0, 16)) - 8);
        endcase
    endfunction

    initial begin
        logic signed [CW-1:0] p [8];
        int gap, burst, mode, sent;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // crossing X, parallel, colinear, degenerate, touching, disjoint
        p = '{-256, -256, 256, 256, -256, 256, 256, -256};
        send_item(0, p); send_item(1, p);
        p = '{0, 0, 256, 0, 0, 256, 256, 256};
        send_item(0, p); send_item(1, p);
        p = '{0, 0, 256, 256, 512, 512, 768, 768};
        send_item(1, p);
        p = '{100, 100, 100, 100, 0, 0, 256, 300};
        send_item(0, p); send_item(1, p);
        p = '{0, 0, 256, 0, 128, 0, 128, 256};
        send_item(1, p);
        p = '{0, 0, 256, 0, 512, -256, 512, 256};
        send_item(1, p); send_item(0, p);
        p = '{0, 0, 256, 256, 10, 300, 9000, 300};
        send_item(1, p);
        // nearly parallel: clamps
        p = '{-32768, 0, 32767, 1, -32768, 1, 32767, 3};
        send_item(0, p);
        p = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767};
        send_item(0, p); send_item(1, p);
        p = '{1, 0, 0, 1, 0, 0, 32767, 32766};
        send_item(0, p);
        foreach (p[i]) p[i] = lsi_pkg::LIM_NEG;
        p[2] = lsi_pkg::LIM_POS; p[5] = lsi_pkg::LIM_POS;
        send_item(0, p); send_item(1, p);
        foreach (p[i]) p[i] = -1;
        send_item(0, p);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 30);
            repeat (burst) begin
                mode = $urandom_range(0, 3);
                foreach (p[i]) p[i] = rand_coord(mode);
                if ($urandom_range(0, 9) == 0) begin
                    p[6] = p[4] + (p[2] - p[0]);
                    p[7] = p[5] + (p[3] - p[1]);
                end
                if ($urandom_range(0, 19) == 0) begin
                    p[2] = p[0]; p[3] = p[1];
                end
                send_item($urandom_range(0, 1), p);
                sent++;
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/lsi_pkg.sv
rtl/core/lsi_front.sv
rtl/core/lsi_div_cell.sv
rtl/core/line_segment_intersection_2d_top.sv
test/lsi_checker.sv
test/tb.sv
